@@ hdl/rsort_pkg.sv @@
// rsort_pkg: shared types, constants and command codes for the record sorter
// used by rsort_cell, rsort_ctrl, rsort_chk, stable_record_sorter_by_key and tb_top
// no dependencies

package rsort_pkg;

	localparam int MAX_RECORDS_DEF = 64;
	localparam int MAX_EMIT        = 64;
	localparam int RANK_W          = 7;
	localparam int JERSEY_W        = 10;
	localparam int RUNS_W          = 20;
	localparam int WICKETS_W       = 16;
	localparam int MATCHES_W       = 16;
	localparam int LIMIT_W         = 7;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SORT_KEY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SORT_ORDER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EMIT_LIMIT = 2'd2;

	localparam logic [LIMIT_W-1:0] EMIT_LIMIT_RST = LIMIT_W'(MAX_EMIT);

	typedef struct packed {
		logic [JERSEY_W-1:0]  jersey;
		logic [RUNS_W-1:0]    runs;
		logic [WICKETS_W-1:0] wickets;
		logic [MATCHES_W-1:0] match_cnt;
	} rec_t;

	typedef struct packed {
		logic valid;
		rec_t rec;
	} cell_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT,
		OP_EVEN,
		OP_ODD,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     tail_valid;
		logic     key_wickets;
		logic     ascending;
	} cell_cmd_t;

	typedef struct packed {
		logic              fire;
		logic [RANK_W-1:0] rank;
		logic              last;
		logic              ovf;
	} emit_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_EMIT
	} state_t;

endpackage

@@ hdl/rsort_cell.sv @@
// rsort_cell: one slot of the sorting chain, holds a record and its valid bit
// shifts toward the head, compare-exchanges with a neighbor, clears
// depends on rsort_pkg

module rsort_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  rsort_pkg::cell_cmd_t cmd,
	input  logic              even_pos,
	input  rsort_pkg::cell_t  left_st,
	input  logic              left_swap,
	input  rsort_pkg::cell_t  right_st,
	output rsort_pkg::cell_t  st,
	output logic              swap_up
);

	logic [rsort_pkg::RUNS_W-1:0] key_me;
	logic [rsort_pkg::RUNS_W-1:0] key_rt;
	logic                         ahead;
	logic                         is_lower;
	rsort_pkg::cell_t             st_d;
	logic                         valid_q;
	rsort_pkg::rec_t              rec_q;

	assign st = {valid_q, rec_q};

	always_comb begin
		key_me = cmd.key_wickets ? rsort_pkg::RUNS_W'(st.rec.wickets) : st.rec.runs;
		key_rt = cmd.key_wickets ? rsort_pkg::RUNS_W'(right_st.rec.wickets) : right_st.rec.runs;
		ahead = cmd.ascending ? (key_rt < key_me) : (key_rt > key_me);
		swap_up = right_st.valid && (!st.valid || ahead);
	end

	always_comb begin
		is_lower = (cmd.op == rsort_pkg::OP_EVEN) ? even_pos : !even_pos;
		st_d = st;
		case (cmd.op)
			rsort_pkg::OP_SHIFT: begin
				st_d = right_st;
			end
			rsort_pkg::OP_EVEN, rsort_pkg::OP_ODD: begin
				if (is_lower && swap_up) begin
					st_d = right_st;
				end else if (!is_lower && left_swap) begin
					st_d = left_st;
				end
			end
			rsort_pkg::OP_CLEAR: begin
				st_d.valid = 1'b0;
			end
			default: begin
				st_d = st;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= st_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= st_d.rec;
	end

endmodule

@@ hdl/rsort_ctrl.sv @@
// rsort_ctrl: batch sequencer for the sorter, load count, sort phases, emit
// drives the cell command and the per-result control fields
// depends on rsort_pkg

module rsort_ctrl #(
	parameter int MAX_RECORDS = rsort_pkg::MAX_RECORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          last_record,
	input  logic                          sort_key,
	input  logic                          sort_order,
	input  logic [rsort_pkg::LIMIT_W-1:0] emit_limit,
	output logic                          busy,
	output rsort_pkg::cell_cmd_t          cmd,
	output rsort_pkg::emit_t              emit
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int PH_W  = $clog2(MAX_RECORDS);
	localparam int CW    = (CNT_W > rsort_pkg::RANK_W) ? CNT_W : rsort_pkg::RANK_W;

	rsort_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]            cnt_q, cnt_d;
	logic                        ovf_q, ovf_d;
	logic [PH_W-1:0]             phase_q, phase_d;
	logic [rsort_pkg::RANK_W-1:0] rank_q, rank_d;
	logic [rsort_pkg::RANK_W-1:0] n_q, n_d;
	logic                        bovf_q, bovf_d;
	logic                        key_q, key_d;
	logic                        order_q, order_d;

	logic                         full;
	logic [CNT_W-1:0]             cnt_nxt;
	logic [rsort_pkg::LIMIT_W-1:0] lim;
	logic [CW-1:0]                cnt_x;
	logic [CW-1:0]                lim_x;
	logic [CW-1:0]                n_x;
	logic                         last_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsort_pkg::ST_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		phase_q <= phase_d;
		rank_q  <= rank_d;
		n_q     <= n_d;
		bovf_q  <= bovf_d;
		key_q   <= key_d;
		order_q <= order_d;
	end

	always_comb begin
		full    = (cnt_q == CNT_W'(MAX_RECORDS));
		cnt_nxt = full ? cnt_q : cnt_q + CNT_W'(1);
		if (emit_limit == '0) begin
			lim = rsort_pkg::LIMIT_W'(1);
		end else if (emit_limit > rsort_pkg::EMIT_LIMIT_RST) begin
			lim = rsort_pkg::EMIT_LIMIT_RST;
		end else begin
			lim = emit_limit;
		end
		cnt_x = CW'(cnt_nxt);
		lim_x = CW'(lim);
		n_x   = (cnt_x < lim_x) ? cnt_x : lim_x;
		last_emit = (rank_q == n_q);
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		phase_d = phase_q;
		rank_d  = rank_q;
		n_d     = n_q;
		bovf_d  = bovf_q;
		key_d   = key_q;
		order_d = order_q;
		cmd.op          = rsort_pkg::OP_HOLD;
		cmd.tail_valid  = 1'b0;
		cmd.key_wickets = key_q;
		cmd.ascending   = order_q;
		emit            = '0;
		busy            = (state_q != rsort_pkg::ST_IDLE);
		unique case (state_q)
			rsort_pkg::ST_IDLE: begin
				if (start) begin
					if (!full) begin
						cmd.op         = rsort_pkg::OP_SHIFT;
						cmd.tail_valid = 1'b1;
						cnt_d          = cnt_nxt;
					end else begin
						ovf_d = 1'b1;
					end
					if (last_record) begin
						state_d = rsort_pkg::ST_SORT;
						phase_d = '0;
						key_d   = sort_key;
						order_d = sort_order;
						n_d     = n_x[rsort_pkg::RANK_W-1:0];
						bovf_d  = ovf_q | full;
						cnt_d   = '0;
						ovf_d   = 1'b0;
					end
				end
			end
			rsort_pkg::ST_SORT: begin
				cmd.op  = phase_q[0] ? rsort_pkg::OP_ODD : rsort_pkg::OP_EVEN;
				phase_d = phase_q + PH_W'(1);
				if (phase_q == PH_W'(MAX_RECORDS - 1)) begin
					state_d = rsort_pkg::ST_EMIT;
					rank_d  = rsort_pkg::RANK_W'(1);
				end
			end
			rsort_pkg::ST_EMIT: begin
				emit.fire = 1'b1;
				emit.rank = rank_q;
				emit.last = last_emit;
				emit.ovf  = bovf_q;
				cmd.op    = last_emit ? rsort_pkg::OP_CLEAR : rsort_pkg::OP_SHIFT;
				rank_d    = rank_q + rsort_pkg::RANK_W'(1);
				if (last_emit) begin
					state_d = rsort_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rsort_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/stable_record_sorter_by_key.sv @@
// stable_record_sorter_by_key: top level, config registers, chain of sort cells,
// sequencer and registered result port
// depends on rsort_pkg, rsort_cell, rsort_ctrl
//
// channel  | handshake                 | payload
// ---------+---------------------------+----------------------------------------------
// input    | start & !busy             | jersey_no runs wickets matches_req last_record
// config   | cfg_valid & cfg_ready     | cfg_index cfg_data
// result   | result_valid, no stall    | rank out_* played overflow last_result
//
// records load one per cycle while busy is low into the tail of a MAX_RECORDS cell chain
// after the last record: alternating even and odd exchange phases, then one result
//   per cycle from the head cell, min(count, limit) results, registered at the port
// busy is high from the cycle after the last record until the final result is out
// reset clears the valid bits and the batch count; cfg_ready is always high

module stable_record_sorter_by_key #(
	parameter int MAX_RECORDS = rsort_pkg::MAX_RECORDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [rsort_pkg::JERSEY_W-1:0]   jersey_no,
	input  logic [rsort_pkg::RUNS_W-1:0]     runs,
	input  logic [rsort_pkg::WICKETS_W-1:0]  wickets,
	input  logic [rsort_pkg::MATCHES_W-1:0]  matches_req,
	input  logic                             last_record,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rsort_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsort_pkg::LIMIT_W-1:0]    cfg_data,
	output logic                             result_valid,
	output logic [rsort_pkg::RANK_W-1:0]     rank,
	output logic [rsort_pkg::JERSEY_W-1:0]   out_jersey_no,
	output logic [rsort_pkg::RUNS_W-1:0]     out_runs,
	output logic [rsort_pkg::WICKETS_W-1:0]  out_wickets,
	output logic [rsort_pkg::MATCHES_W-1:0]  out_matches,
	output logic                             played,
	output logic                             overflow,
	output logic                             last_result
);

	logic                          sort_key_q;
	logic                          sort_order_q;
	logic [rsort_pkg::LIMIT_W-1:0] emit_limit_q;

	rsort_pkg::cell_cmd_t cmd;
	rsort_pkg::emit_t     emit;
	rsort_pkg::cell_t     tail;
	rsort_pkg::cell_t     st [MAX_RECORDS];
	logic                 swp [MAX_RECORDS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_key_q   <= 1'b0;
			sort_order_q <= 1'b0;
			emit_limit_q <= rsort_pkg::EMIT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rsort_pkg::REG_SORT_KEY:   sort_key_q   <= cfg_data[0];
				rsort_pkg::REG_SORT_ORDER: sort_order_q <= cfg_data[0];
				rsort_pkg::REG_EMIT_LIMIT: emit_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rsort_ctrl #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_record(last_record),
		.sort_key   (sort_key_q),
		.sort_order (sort_order_q),
		.emit_limit (emit_limit_q),
		.busy       (busy),
		.cmd        (cmd),
		.emit       (emit)
	);

	always_comb begin
		tail.valid         = cmd.tail_valid;
		tail.rec.jersey    = jersey_no;
		tail.rec.runs      = runs;
		tail.rec.wickets   = wickets;
		tail.rec.match_cnt = matches_req;
	end

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		rsort_pkg::cell_t left_st;
		rsort_pkg::cell_t right_st;
		logic             left_swap;

		if (i == 0) begin : g_head
			assign left_st   = '0;
			assign left_swap = 1'b0;
		end else begin : g_mid
			assign left_st   = st[i-1];
			assign left_swap = swp[i-1];
		end

		if (i == MAX_RECORDS - 1) begin : g_tail
			assign right_st = tail;
		end else begin : g_body
			assign right_st = st[i+1];
		end

		rsort_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.even_pos ((i % 2) == 0),
			.left_st  (left_st),
			.left_swap(left_swap),
			.right_st (right_st),
			.st       (st[i]),
			.swap_up  (swp[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= emit.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.fire) begin
			rank          <= emit.rank;
			out_jersey_no <= st[0].rec.jersey;
			out_runs      <= st[0].rec.runs;
			out_wickets   <= st[0].rec.wickets;
			out_matches   <= st[0].rec.match_cnt;
			played        <= (st[0].rec.match_cnt != '0);
			overflow      <= emit.ovf;
			last_result   <= emit.last;
		end
	end

endmodule

@@ hdl/rsort_chk.sv @@
// rsort_chk: port-level checks on the record sorter's result sequence
// bound to stable_record_sorter_by_key; depends on rsort_pkg

module rsort_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          last_record,
	input logic                          busy,
	input logic                          result_valid,
	input logic [rsort_pkg::RANK_W-1:0]  rank,
	input logic                          last_result
);

	// a batch end makes the block busy
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_record |=> busy)
		else $error("busy not raised after last record beat");

	// results of one batch come out back to back
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |=> result_valid)
		else $error("gap inside result burst");

	// ranks count up by one
	a_rank_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |=> rank == $past(rank) + rsort_pkg::RANK_W'(1))
		else $error("rank did not step by one");

	// a non-final result is only shown while busy
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |-> busy)
		else $error("result shown while idle");

	// first result of a batch has rank one
	a_rank_one: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> rank == rsort_pkg::RANK_W'(1))
		else $error("burst does not start at rank one");

endmodule

bind stable_record_sorter_by_key rsort_chk u_rsort_chk (.*);

@@ dv/tb_top.sv @@
// tb_top: self-checking bench for stable_record_sorter_by_key, streams record batches,
// predicts the ranked output of each batch and compares it beat by beat
// depends on rsort_pkg and stable_record_sorter_by_key
`timescale 1ns / 1ps

module tb_top;

	localparam int STORE_DEPTH = rsort_pkg::MAX_RECORDS_DEF;
	localparam logic [rsort_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		rsort_pkg::rec_t rec;
		logic            last;
	} load_beat_t;

	typedef struct packed {
		logic [rsort_pkg::RANK_W-1:0] rank;
		rsort_pkg::rec_t              rec;
		logic                         played;
		logic                         ovf;
		logic                         last;
	} ranked_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [rsort_pkg::JERSEY_W-1:0] jersey_no = '0;
	logic [rsort_pkg::RUNS_W-1:0] runs = '0;
	logic [rsort_pkg::WICKETS_W-1:0] wickets = '0;
	logic [rsort_pkg::MATCHES_W-1:0] matches_req = '0;
	logic last_record = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rsort_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rsort_pkg::LIMIT_W-1:0] cfg_data = '0;
	logic result_valid;
	logic [rsort_pkg::RANK_W-1:0] rank;
	logic [rsort_pkg::JERSEY_W-1:0] out_jersey_no;
	logic [rsort_pkg::RUNS_W-1:0] out_runs;
	logic [rsort_pkg::WICKETS_W-1:0] out_wickets;
	logic [rsort_pkg::MATCHES_W-1:0] out_matches;
	logic played;
	logic overflow;
	logic last_result;

	// predictor state and config copy
	rsort_pkg::rec_t batch_recs[$];
	logic batch_dropped = 1'b0;
	logic key_wickets = 1'b0;
	logic ascending = 1'b0;
	logic [rsort_pkg::LIMIT_W-1:0] emit_cap = rsort_pkg::EMIT_LIMIT_RST;

	load_beat_t load_beats[$];
	ranked_t ranked_due[$];

	int burst_left = 1;
	int gap_left = 0;
	int mismatches = 0;
	int batches_done = 0;
	int records_loaded = 0;
	int results_seen = 0;
	int overflow_batches = 0;
	int random_items = 0;

	stable_record_sorter_by_key dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.jersey_no(jersey_no),
		.runs(runs),
		.wickets(wickets),
		.matches_req(matches_req),
		.last_record(last_record),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.rank(rank),
		.out_jersey_no(out_jersey_no),
		.out_runs(out_runs),
		.out_wickets(out_wickets),
		.out_matches(out_matches),
		.played(played),
		.overflow(overflow),
		.last_result(last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("[%0t] MISMATCH %s", $realtime, msg);
	endtask

	task automatic check_field(input int unsigned at_rank, input string name,
			input int unsigned got, input int unsigned want);
		if (got != want)
			flag_mismatch($sformatf("rank %0d %s: got %0d want %0d", at_rank, name, got, want));
	endtask

	function automatic int unsigned sort_key_of(input rsort_pkg::rec_t r);
		return key_wickets ? int'(r.wickets) : int'(r.runs);
	endfunction

	function automatic bit goes_ahead(input rsort_pkg::rec_t a, input rsort_pkg::rec_t b);
		int unsigned ka;
		int unsigned kb;
		ka = sort_key_of(a);
		kb = sort_key_of(b);
		return ascending ? (ka < kb) : (ka > kb);
	endfunction

	// stable insertion sort of the batch, then queue the ranked records
	task automatic rank_batch();
		rsort_pkg::rec_t srt[$];
		rsort_pkg::rec_t cur;
		ranked_t r;
		int i;
		int j;
		int lim;
		int n;
		srt = batch_recs;
		for (i = 1; i < srt.size(); i++) begin
			cur = srt[i];
			j = i;
			while (j > 0 && goes_ahead(cur, srt[j-1])) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = cur;
		end
		lim = (emit_cap == 0) ? 1 :
			((emit_cap > rsort_pkg::MAX_EMIT) ? rsort_pkg::MAX_EMIT : int'(emit_cap));
		n = (srt.size() < lim) ? srt.size() : lim;
		for (i = 0; i < n; i++) begin
			r.rank = rsort_pkg::RANK_W'(i + 1);
			r.rec = srt[i];
			r.played = (srt[i].match_cnt != 0);
			r.ovf = batch_dropped;
			r.last = (i == n - 1);
			ranked_due.push_back(r);
		end
		if (batch_dropped)
			overflow_batches++;
		batches_done++;
		batch_recs.delete();
		batch_dropped = 1'b0;
	endtask

	// monitor: config beats, accepted records and result beats
	always @(posedge clk) begin
		load_beat_t b;
		ranked_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rsort_pkg::REG_SORT_KEY: key_wickets = cfg_data[0];
					rsort_pkg::REG_SORT_ORDER: ascending = cfg_data[0];
					rsort_pkg::REG_EMIT_LIMIT: emit_cap = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				b.rec.jersey = jersey_no;
				b.rec.runs = runs;
				b.rec.wickets = wickets;
				b.rec.match_cnt = matches_req;
				b.last = last_record;
				records_loaded++;
				if (batch_recs.size() < STORE_DEPTH)
					batch_recs.push_back(b.rec);
				else
					batch_dropped = 1'b1;
				if (b.last)
					rank_batch();
				if (load_beats.size() > 0)
					void'(load_beats.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else if (gap_left > 0) begin
				gap_left--;
			end
			if (result_valid) begin
				results_seen++;
				if (ranked_due.size() == 0) begin
					flag_mismatch($sformatf("result beat rank %0d with nothing pending", rank));
				end else begin
					want = ranked_due.pop_front();
					check_field(want.rank, "rank", rank, want.rank);
					check_field(want.rank, "jersey", out_jersey_no, want.rec.jersey);
					check_field(want.rank, "runs", out_runs, want.rec.runs);
					check_field(want.rank, "wickets", out_wickets, want.rec.wickets);
					check_field(want.rank, "matches", out_matches, want.rec.match_cnt);
					check_field(want.rank, "played", played, want.played);
					check_field(want.rank, "overflow", overflow, want.ovf);
					check_field(want.rank, "last", last_result, want.last);
				end
			end
		end
	end

	// driver: bursts of record beats with random gaps, junk payload while idle
	always @(negedge clk) begin
		load_beat_t b;
		logic drive;
		drive = 1'b0;
		if (arst_n && gap_left == 0 && load_beats.size() > 0)
			drive = 1'b1;
		if (drive) begin
			b = load_beats[0];
			start <= 1'b1;
			jersey_no <= b.rec.jersey;
			runs <= b.rec.runs;
			wickets <= b.rec.wickets;
			matches_req <= b.rec.match_cnt;
			last_record <= b.last;
		end else begin
			start <= 1'b0;
			jersey_no <= rsort_pkg::JERSEY_W'($urandom);
			runs <= rsort_pkg::RUNS_W'($urandom);
			wickets <= rsort_pkg::WICKETS_W'($urandom);
			matches_req <= rsort_pkg::MATCHES_W'($urandom);
			last_record <= 1'($urandom);
		end
	end

	task automatic write_reg(input logic [rsort_pkg::CFG_IDX_W-1:0] idx,
			input logic [rsort_pkg::LIMIT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data <= rsort_pkg::LIMIT_W'($urandom);
	endtask

	task automatic set_sort(input logic key, input logic asc,
			input logic [rsort_pkg::LIMIT_W-1:0] lim);
		write_reg(rsort_pkg::REG_SORT_KEY, {6'($urandom_range(0, 63)), key});
		write_reg(rsort_pkg::REG_SORT_ORDER, {6'($urandom_range(0, 63)), asc});
		write_reg(rsort_pkg::REG_EMIT_LIMIT, lim);
	endtask

	task automatic wait_idle();
		while (load_beats.size() != 0 || ranked_due.size() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic push_rec(input int unsigned j, input int unsigned r, input int unsigned w,
			input int unsigned m, input logic last);
		load_beat_t b;
		b.rec.jersey = rsort_pkg::JERSEY_W'(j);
		b.rec.runs = rsort_pkg::RUNS_W'(r);
		b.rec.wickets = rsort_pkg::WICKETS_W'(w);
		b.rec.match_cnt = rsort_pkg::MATCHES_W'(m);
		b.last = last;
		load_beats.push_back(b);
	endtask

	// narrow keys give plenty of ties to exercise stability
	task automatic push_batch(input int n, input bit tie_heavy);
		int i;
		int unsigned r;
		int unsigned w;
		for (i = 0; i < n; i++) begin
			r = tie_heavy ? $urandom_range(0, 3) : $urandom_range(0, 'hFFFFF);
			w = tie_heavy ? $urandom_range(0, 3) : $urandom_range(0, 'hFFFF);
			if ($urandom_range(0, 9) == 0)
				r = 'hFFFFF;
			if ($urandom_range(0, 9) == 0)
				w = 'hFFFF;
			push_rec($urandom_range(0, 1023), r, w,
				($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 'hFFFF), i == n - 1);
			random_items++;
		end
	endtask

	function automatic logic [rsort_pkg::LIMIT_W-1:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return rsort_pkg::LIMIT_W'(1);
			1: return rsort_pkg::LIMIT_W'(2);
			2: return rsort_pkg::LIMIT_W'(3);
			3: return rsort_pkg::LIMIT_W'(64);
			4: return rsort_pkg::LIMIT_W'(0);
			5: return rsort_pkg::LIMIT_W'(127);
			6: return rsort_pkg::LIMIT_W'($urandom_range(1, 127));
			default: return rsort_pkg::LIMIT_W'($urandom_range(4, 12));
		endcase
	endfunction

	initial begin
		int phase_no;
		int k;
		logic [rsort_pkg::LIMIT_W-1:0] lim;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: runs, largest first, full limit; extremes and key ties
		push_rec(1023, 'hFFFFF, 0, 0, 1'b0);
		push_rec(0, 0, 'hFFFF, 'hFFFF, 1'b0);
		push_rec(1, 500, 7, 1, 1'b0);
		push_rec(2, 500, 7, 0, 1'b0);
		push_rec(3, 500, 9, 3, 1'b1);
		push_rec(77, 12, 34, 0, 1'b1);
		wait_idle();

		// wickets, smallest first, top three
		set_sort(1'b1, 1'b1, rsort_pkg::LIMIT_W'(3));
		push_rec(10, 5, 40, 2, 1'b0);
		push_rec(11, 6, 3, 0, 1'b0);
		push_rec(12, 7, 40, 5, 1'b0);
		push_rec(13, 8, 3, 9, 1'b0);
		push_rec(14, 9, 0, 1, 1'b0);
		push_rec(15, 1, 'hFFFF, 0, 1'b1);
		wait_idle();

		// limit zero acts as one; unused index is ignored
		set_sort(1'b1, 1'b0, rsort_pkg::LIMIT_W'(0));
		write_reg(REG_UNUSED, rsort_pkg::LIMIT_W'($urandom));
		push_rec(20, 1, 'hFFFF, 4, 1'b0);
		push_rec(21, 2, 'hFFFF, 5, 1'b0);
		push_rec(22, 3, 100, 6, 1'b1);
		wait_idle();

		// limit above the maximum saturates
		set_sort(1'b0, 1'b1, rsort_pkg::LIMIT_W'(127));
		push_rec(30, 'hFFFFF, 1, 1, 1'b0);
		push_rec(31, 0, 2, 0, 1'b0);
		push_rec(32, 0, 3, 7, 1'b0);
		push_rec(33, 'h80000, 4, 'h8000, 1'b1);

		phase_no = 0;
		while (random_items < 290) begin
			wait_idle();
			if (phase_no == 3)
				lim = rsort_pkg::LIMIT_W'(64);
			else if (phase_no == 7)
				lim = rsort_pkg::LIMIT_W'(127);
			else
				lim = pick_limit();
			set_sort(1'($urandom), 1'($urandom), lim);
			if (phase_no == 3) begin
				push_batch(STORE_DEPTH, 1'b0);
			end else if (phase_no == 7) begin
				push_batch(STORE_DEPTH + 1 + $urandom_range(0, 2), 1'($urandom));
			end else begin
				for (k = $urandom_range(1, 4); k > 0; k--)
					push_batch($urandom_range(1, 12), 1'($urandom));
			end
			phase_no++;
		end

		wait_idle();
		repeat (2 * STORE_DEPTH + 16) @(posedge clk);
		$display("covered %0d batches over %0d settings, %0d records loaded",
			batches_done, phase_no + 4, records_loaded);
		$display("checked %0d ranked beats, %0d batches overran the store",
			results_seen, overflow_batches);
		if (mismatches == 0 && ranked_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d beats still pending", ranked_due.size());
		$display("Verification failed");
		$finish;
	end

endmodule
